// File: hw/rtl/tbrd_pkg.sv
package tbrd_pkg;

  localparam logic [7:0] WORD_LIMIT    = 8'd98;
  localparam logic [6:0] NAMED_KEY     = 7'd98;

  localparam logic [7:0] TAG_IP        = 8'd255;
  localparam logic [7:0] TAG_BLOB32    = 8'd254;
  localparam logic [7:0] TAG_BLOB33    = 8'd253;
  localparam logic [7:0] TAG_BLOB65    = 8'd252;
  localparam logic [7:0] TAG_BLOB20    = 8'd251;
  localparam logic [7:0] TAG_NUM_HI    = 8'd250;
  localparam logic [7:0] TAG_NUM_LO    = 8'd239;
  localparam logic [7:0] NUM_LEN_BASE  = 8'd252;
  localparam logic [7:0] TAG_AMOUNT    = 8'd238;
  localparam logic [7:0] TAG_NTXT8_LO  = 8'd236;
  localparam logic [7:0] TAG_TS_BASE   = 8'd235;
  localparam logic [7:0] TAG_TS_OFF8   = 8'd234;
  localparam logic [7:0] TAG_TS_OFF16  = 8'd233;
  localparam logic [7:0] TAG_ZERO      = 8'd232;
  localparam logic [7:0] TAG_ZERO_TXT  = 8'd231;
  localparam logic [7:0] TAG_COIN      = 8'd230;
  localparam logic [7:0] TAG_TEXT      = 8'd229;
  localparam logic [7:0] TAG_ARR8      = 8'd228;
  localparam logic [7:0] TAG_ARR16     = 8'd227;
  localparam logic [7:0] TAG_ARR32     = 8'd226;

  localparam logic [6:0] LEN_BLOB32    = 7'd32;
  localparam logic [6:0] LEN_BLOB33    = 7'd33;
  localparam logic [6:0] LEN_BLOB65    = 7'd65;
  localparam logic [6:0] LEN_BLOB20    = 7'd20;

  localparam logic [3:0] K_KEY         = 4'd0;
  localparam logic [3:0] K_NAME        = 4'd1;
  localparam logic [3:0] K_ARRAY       = 4'd2;
  localparam logic [3:0] K_NUMBER      = 4'd3;
  localparam logic [3:0] K_NUM_TEXT    = 4'd4;
  localparam logic [3:0] K_AMOUNT      = 4'd5;
  localparam logic [3:0] K_IP          = 4'd6;
  localparam logic [3:0] K_TIMESTAMP   = 4'd7;
  localparam logic [3:0] K_BLOB        = 4'd8;
  localparam logic [3:0] K_TEXT        = 4'd9;
  localparam logic [3:0] K_COIN        = 4'd10;
  localparam logic [3:0] K_WORD        = 4'd11;
  localparam logic [3:0] K_ERROR       = 4'd12;
  localparam logic [3:0] K_END         = 4'd13;

  localparam logic [2:0] E_NONE        = 3'd0;
  localparam logic [2:0] E_BAD_KEY     = 3'd1;
  localparam logic [2:0] E_SECOND_TS   = 3'd2;
  localparam logic [2:0] E_BAD_VALUE   = 3'd3;
  localparam logic [2:0] E_TRUNCATED   = 3'd4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [6:0]  key_index;
    logic [63:0] value;
    logic [1:0]  blob;
    logic        last;
    logic [2:0]  err;
    logic        done;
  } tbrd_token_t;

endpackage

// File: hw/rtl/tbrd_in_if.sv
interface tbrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, output data_byte, output packet_last, input ready);
  modport sink (input valid, input data_byte, input packet_last, output ready);
endinterface

// File: hw/rtl/tbrd_out_if.sv
interface tbrd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [6:0]  key_index;
  logic [63:0] token_value;
  logic [1:0]  blob_kind;
  logic        part_last;
  logic [2:0]  error_code;
  logic        packet_done;

  modport source (output valid, output token_kind, output key_index, output token_value,
                  output blob_kind, output part_last, output error_code,
                  output packet_done, input ready);
  modport sink (input valid, input token_kind, input key_index, input token_value,
                input blob_kind, input part_last, input error_code,
                input packet_done, output ready);
endinterface

// File: hw/rtl/tbrd_core.sv
module tbrd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               packet_last,
  output logic               has_tok,
  output tbrd_pkg::tbrd_token_t tok
);
  import tbrd_pkg::*;

  typedef enum logic [2:0] {
    PH_KEY, PH_NAME, PH_HEADER, PH_COUNT, PH_VTAG, PH_PAYLOAD, PH_BLOB, PH_TEXT
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  value_tag, value_tag_next;
  logic [6:0]  bytes_left, bytes_left_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [63:0] value_accum, value_accum_next;
  logic [31:0] base_timestamp, base_timestamp_next;
  logic [31:0] array_items_left, array_items_left_next;
  logic [6:0]  current_key, current_key_next;
  logic        discard_mode, discard_mode_next;

  logic        clear;
  logic        do_start;
  logic        fin;
  logic        is_err;
  logic [2:0]  err_code;
  logic [63:0] acc_v;
  logic [6:0]  left_dec;
  phase_t      fin_phase;
  logic [31:0] fin_items;
  logic [7:0]  num_len;

  always_comb begin
    phase_next            = phase;
    value_tag_next        = value_tag;
    bytes_left_next       = bytes_left;
    byte_position_next    = byte_position;
    value_accum_next      = value_accum;
    base_timestamp_next   = base_timestamp;
    array_items_left_next = array_items_left;
    current_key_next      = current_key;
    discard_mode_next     = discard_mode;
    clear    = 1'b0;
    do_start = 1'b0;
    fin      = 1'b0;
    is_err   = 1'b0;
    err_code = E_NONE;
    has_tok  = 1'b0;
    tok      = '0;

    acc_v = value_accum;
    acc_v[{byte_position, 3'b000} +: 8] = value_accum[{byte_position, 3'b000} +: 8] | data_byte;
    left_dec  = (bytes_left != 7'd0) ? bytes_left - 7'd1 : 7'd0;
    fin_phase = (array_items_left > 32'd1) ? PH_VTAG : PH_KEY;
    fin_items = (array_items_left != 32'd0) ? array_items_left - 32'd1 : 32'd0;
    num_len   = (NUM_LEN_BASE - data_byte) >> 1;

    if (discard_mode) begin
      clear = packet_last;
    end else if (packet_last && phase == PH_KEY) begin
      has_tok  = 1'b1;
      tok.kind = K_END;
      clear    = 1'b1;
    end else begin
      case (phase)
        PH_KEY: begin
          if (data_byte < WORD_LIMIT) begin
            current_key_next = data_byte[6:0];
            has_tok   = 1'b1;
            tok.kind  = K_KEY;
            tok.value = {56'd0, data_byte};
            phase_next = PH_HEADER;
          end else if (data_byte == TAG_TEXT) begin
            current_key_next = NAMED_KEY;
            has_tok   = 1'b1;
            tok.kind  = K_KEY;
            tok.value = {57'd0, NAMED_KEY};
            phase_next = PH_NAME;
          end else begin
            is_err   = 1'b1;
            err_code = E_BAD_KEY;
          end
        end
        PH_NAME: begin
          has_tok   = 1'b1;
          tok.kind  = K_NAME;
          tok.value = {56'd0, data_byte};
          if (data_byte == 8'd0) begin
            tok.last   = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (data_byte == TAG_ARR8 || data_byte == TAG_ARR16 || data_byte == TAG_ARR32) begin
            value_tag_next     = data_byte;
            byte_position_next = 3'd0;
            value_accum_next   = '0;
            phase_next         = PH_COUNT;
            if (data_byte == TAG_ARR8) begin
              bytes_left_next = 7'd1;
            end else if (data_byte == TAG_ARR16) begin
              bytes_left_next = 7'd2;
            end else begin
              bytes_left_next = 7'd4;
            end
          end else begin
            do_start = 1'b1;
          end
        end
        PH_COUNT: begin
          value_accum_next   = acc_v;
          byte_position_next = byte_position + 3'd1;
          bytes_left_next    = left_dec;
          if (left_dec == 7'd0) begin
            array_items_left_next = acc_v[31:0];
            has_tok   = 1'b1;
            tok.kind  = K_ARRAY;
            tok.value = {32'd0, acc_v[31:0]};
            phase_next = (acc_v[31:0] != 32'd0) ? PH_VTAG : PH_KEY;
          end
        end
        PH_VTAG: begin
          do_start = 1'b1;
        end
        PH_PAYLOAD: begin
          value_accum_next   = acc_v;
          byte_position_next = byte_position + 3'd1;
          bytes_left_next    = left_dec;
          if (left_dec == 7'd0) begin
            fin     = 1'b1;
            has_tok = 1'b1;
            tok.value = acc_v;
            if (value_tag == TAG_IP) begin
              tok.kind = K_IP;
            end else if (value_tag >= TAG_NUM_LO) begin
              tok.kind = value_tag[0] ? K_NUM_TEXT : K_NUMBER;
            end else if (value_tag == TAG_AMOUNT) begin
              tok.kind = K_AMOUNT;
            end else if (value_tag >= TAG_NTXT8_LO) begin
              tok.kind = K_NUM_TEXT;
            end else if (value_tag == TAG_TS_BASE) begin
              base_timestamp_next = acc_v[31:0];
              tok.kind  = K_TIMESTAMP;
              tok.value = {32'd0, acc_v[31:0]};
            end else if (value_tag == TAG_TS_OFF8) begin
              tok.kind  = K_TIMESTAMP;
              tok.value = {32'd0, base_timestamp + acc_v[31:0]};
            end else if (value_tag == TAG_TS_OFF16) begin
              tok.kind  = K_TIMESTAMP;
              tok.value = {32'd0, base_timestamp} + acc_v;
            end else begin
              tok.kind = K_COIN;
            end
          end
        end
        PH_BLOB: begin
          has_tok   = 1'b1;
          tok.kind  = K_BLOB;
          tok.value = {56'd0, data_byte};
          tok.blob  = 2'(TAG_BLOB32 - value_tag);
          bytes_left_next = left_dec;
          if (left_dec == 7'd0) begin
            tok.last = 1'b1;
            fin      = 1'b1;
          end
        end
        PH_TEXT: begin
          has_tok   = 1'b1;
          tok.kind  = K_TEXT;
          tok.value = {56'd0, data_byte};
          if (data_byte == 8'd0) begin
            tok.last = 1'b1;
            fin      = 1'b1;
          end
        end
        default: begin
          phase_next = PH_KEY;
        end
      endcase

      if (do_start) begin
        if (data_byte < WORD_LIMIT) begin
          has_tok   = 1'b1;
          tok.kind  = K_WORD;
          tok.value = {56'd0, data_byte};
          fin       = 1'b1;
        end else if (data_byte == TAG_ZERO) begin
          has_tok  = 1'b1;
          tok.kind = K_NUMBER;
          fin      = 1'b1;
        end else if (data_byte == TAG_ZERO_TXT) begin
          has_tok  = 1'b1;
          tok.kind = K_NUM_TEXT;
          fin      = 1'b1;
        end else if (data_byte == TAG_TEXT) begin
          value_tag_next = data_byte;
          phase_next     = PH_TEXT;
        end else if (data_byte == TAG_TS_BASE && base_timestamp != 32'd0) begin
          is_err   = 1'b1;
          err_code = E_SECOND_TS;
        end else if (data_byte inside {[TAG_BLOB20:TAG_BLOB32]} || data_byte == TAG_IP ||
                     data_byte inside {[TAG_TS_OFF16:TAG_NUM_HI]} || data_byte == TAG_COIN)
        begin
          value_tag_next     = data_byte;
          byte_position_next = 3'd0;
          value_accum_next   = '0;
          phase_next         = PH_PAYLOAD;
          if (data_byte == TAG_IP || data_byte == TAG_TS_BASE) begin
            bytes_left_next = 7'd4;
          end else if (data_byte == TAG_BLOB32) begin
            bytes_left_next = LEN_BLOB32;
            phase_next      = PH_BLOB;
          end else if (data_byte == TAG_BLOB33) begin
            bytes_left_next = LEN_BLOB33;
            phase_next      = PH_BLOB;
          end else if (data_byte == TAG_BLOB65) begin
            bytes_left_next = LEN_BLOB65;
            phase_next      = PH_BLOB;
          end else if (data_byte == TAG_BLOB20) begin
            bytes_left_next = LEN_BLOB20;
            phase_next      = PH_BLOB;
          end else if (data_byte >= TAG_NUM_LO) begin
            bytes_left_next = num_len[6:0];
          end else if (data_byte >= TAG_NTXT8_LO) begin
            bytes_left_next = 7'd8;
          end else if (data_byte == TAG_TS_OFF16) begin
            bytes_left_next = 7'd2;
          end else begin
            bytes_left_next = 7'd1;
          end
        end else begin
          is_err   = 1'b1;
          err_code = E_BAD_VALUE;
        end
      end

      if (fin) begin
        phase_next            = fin_phase;
        array_items_left_next = fin_items;
      end

      if (is_err) begin
        has_tok  = 1'b1;
        tok      = '0;
        tok.kind = K_ERROR;
        tok.err  = err_code;
        clear    = packet_last;
        discard_mode_next = ~packet_last;
      end else if (packet_last) begin
        if (phase_next != PH_KEY) begin
          tok      = '0;
          tok.kind = K_ERROR;
          tok.err  = E_TRUNCATED;
        end else if (!has_tok) begin
          tok.kind = K_END;
        end
        has_tok = 1'b1;
        clear   = 1'b1;
      end
    end

    tok.key_index = current_key_next;
    tok.done      = packet_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && clear)) begin
      phase            <= PH_KEY;
      value_tag        <= '0;
      bytes_left       <= '0;
      byte_position    <= '0;
      value_accum      <= '0;
      base_timestamp   <= '0;
      array_items_left <= '0;
      current_key      <= '0;
      discard_mode     <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      value_tag        <= value_tag_next;
      bytes_left       <= bytes_left_next;
      byte_position    <= byte_position_next;
      value_accum      <= value_accum_next;
      base_timestamp   <= base_timestamp_next;
      array_items_left <= array_items_left_next;
      current_key      <= current_key_next;
      discard_mode     <= discard_mode_next;
    end
  end

endmodule

// File: hw/rtl/tbrd_out_stage.sv
module tbrd_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  has_tok,
  input  tbrd_pkg::tbrd_token_t tok_in,
  input  logic                  take,
  output logic                  space,
  output logic                  valid,
  output tbrd_pkg::tbrd_token_t tok
);
  import tbrd_pkg::*;

  assign space = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= has_tok;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && has_tok) begin
      tok <= tok_in;
    end
  end

endmodule

// File: hw/rtl/tagged_binary_record_decoder.sv
// Decodes a tagged binary record stream one byte per request and gives at most one token per
// byte. A byte is taken in every cycle in which the result register is empty or its token is
// being taken, so the sustained rate is one byte per cycle while the result side keeps taking
// tokens; the token for a byte appears in the result register on the cycle after the byte is
// accepted. All parse state is updated in that single cycle, and the only path from the result
// side to the input side is the ready line. After an error token the rest of the packet is
// dropped without tokens, and every packet end returns the parser to its reset state.
module tagged_binary_record_decoder (
  input logic       clk,
  input logic       rst,
  tbrd_in_if.sink   in_ch,
  tbrd_out_if.source out_ch
);
  import tbrd_pkg::*;

  logic        accept;
  logic        has_tok;
  logic        space;
  tbrd_token_t tok_next;
  tbrd_token_t tok;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  tbrd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .packet_last (in_ch.packet_last),
    .has_tok     (has_tok),
    .tok         (tok_next)
  );

  tbrd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .has_tok (has_tok),
    .tok_in  (tok_next),
    .take    (out_ch.ready),
    .space   (space),
    .valid   (out_ch.valid),
    .tok     (tok)
  );

  assign out_ch.token_kind  = tok.kind;
  assign out_ch.key_index   = tok.key_index;
  assign out_ch.token_value = tok.value;
  assign out_ch.blob_kind   = tok.blob;
  assign out_ch.part_last   = tok.last;
  assign out_ch.error_code  = tok.err;
  assign out_ch.packet_done = tok.done;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> !out_ch.valid || out_ch.ready)
    else $error("request accepted while a stalled token would be overwritten");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.token_kind == K_ERROR) == (out_ch.error_code != E_NONE)))
    else $error("error code does not match token kind");

  a_part_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.part_last |->
      out_ch.token_kind == K_NAME || out_ch.token_kind == K_BLOB ||
      out_ch.token_kind == K_TEXT)
    else $error("part_last on a token without parts");

  a_blob_kind: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.blob_kind != 2'd0 |-> out_ch.token_kind == K_BLOB)
    else $error("blob kind set on a token that is not a blob byte");

endmodule
